// File: design/bemf_commutation_period_filter_macros.svh
// ---------------------------------------------------------------------------
// bemf commutation period filter assertion macros
// shared concurrent assertion forms for the period filter block
// ---------------------------------------------------------------------------
`ifndef BEMF_COMMUTATION_PERIOD_FILTER_MACROS_SVH
`define BEMF_COMMUTATION_PERIOD_FILTER_MACROS_SVH

// same-cycle implication, checked outside reset
`define BCPF_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked outside reset
`define BCPF_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: design/bcpf_pkg.sv
// ---------------------------------------------------------------------------
// bcpf package
// types and constants of the back-emf commutation period filter
// ---------------------------------------------------------------------------
package bcpf_pkg;

   localparam int unsigned STEP_SHIFT        = 1;
   localparam int unsigned READY_COUNT_DEF   = 20;
   localparam logic [15:0] GAP_LIMIT         = 16'd64535;
   localparam int unsigned CSR_INDEX_W       = 2;
   localparam int unsigned CSR_DATA_W        = 16;

   localparam logic [CSR_INDEX_W-1:0] CSR_TIMING_ADVANCE = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_FILTER_POLE    = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_LOOP_ENABLE    = 2'd2;

   typedef struct packed {
      logic [15:0] capture_now;
      logic [15:0] capture_before;
      logic [7:0]  overflow_count;
   } req_item_type;

   typedef struct packed {
      logic [15:0] period;
      logic        gap_valid;
      logic        lock_ready;
      logic        commutate;
   } rsp_item_type;

   // divider status toward the sequencer
   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

// File: design/bcpf_div.sv
// ---------------------------------------------------------------------------
// bcpf divider
// restoring divider, one quotient bit per cycle, 16-bit quotient
// ---------------------------------------------------------------------------
module bcpf_div (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic [31:0]             dividend,
   input  logic [16:0]             divisor,
   output bcpf_pkg::div_status_type status,
   output logic [15:0]             quotient
);
   import bcpf_pkg::*;

   logic [16:0] rem_ff, rem_in;
   logic [15:0] q_ff, q_in;
   logic [16:0] div_ff;
   logic [3:0]  count_ff;
   logic        busy_ff;
   logic        done_ff;
   logic [17:0] shifted;
   logic [17:0] trial;

   // caller guarantees dividend[31:16] < divisor, so 16 steps suffice
   always_comb begin
      shifted = {rem_ff, q_ff[15]};
      trial   = shifted - {1'b0, div_ff};
      if (!trial[17]) begin
         rem_in = trial[16:0];
      end else begin
         rem_in = shifted[16:0];
      end
      q_in = {q_ff[14:0], ~trial[17]};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         if (start) begin
            busy_ff  <= 1'b1;
            done_ff  <= 1'b0;
            count_ff <= '1;
            rem_ff   <= {1'b0, dividend[31:16]};
            q_ff     <= dividend[15:0];
            div_ff   <= divisor;
         end else if (busy_ff) begin
            rem_ff   <= rem_in;
            q_ff     <= q_in;
            count_ff <= count_ff - 4'd1;
            done_ff  <= (count_ff == '0);
            if (count_ff == '0) begin
               busy_ff <= 1'b0;
            end
         end else begin
            done_ff <= 1'b0;
         end
      end
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign quotient    = q_ff;

endmodule

// File: design/bemf_commutation_period_filter.sv
// ---------------------------------------------------------------------------
// bemf commutation period filter
// range check and iir smoothing of back-emf zero-crossing gaps
// ---------------------------------------------------------------------------
// Each item is one zero-crossing event (two 16-bit timer captures and the
// overflow count between them). A valid event folds half the sum of its
// gap and the signed advance (a quarter with a step shift of two) into the
// stored period as (period*pole + x)/(pole+1); an invalid event keeps the
// period and clears the lock run. One result item leaves per event. The
// block handles one event at a time: a valid event passes through the
// multiply step, the divider load step, 16 restoring divider steps of one
// quotient bit each, the period update on divider done and the step that
// registers the result before req_ready returns; a rejected event goes
// straight to the result register step. The result sits in an output
// register, and req_ready stays low until the event is finished and its
// result is registered; an event that finishes while the previous result
// is still waiting holds in its last state until that result is taken.
// Configuration registers are written through csr_we/csr_index/csr_wdata;
// the user must write them only while the block is idle, which the block
// itself does not enforce; index 3 is ignored.
// ---------------------------------------------------------------------------
module bemf_commutation_period_filter #(
   parameter int unsigned READY_COUNT = bcpf_pkg::READY_COUNT_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // event input
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  bcpf_pkg::req_item_type               req_item,
   // result output
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output bcpf_pkg::rsp_item_type               rsp_item,
   // configuration
   input  logic                                 csr_we,
   input  logic [bcpf_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [bcpf_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import bcpf_pkg::*;

   localparam int unsigned RUN_W = $clog2(READY_COUNT + 1);
   localparam logic [RUN_W-1:0] RUN_MAX = RUN_W'(READY_COUNT);

   typedef enum logic [2:0] {
      S_IDLE,
      S_MUL,
      S_LOAD,
      S_DIV,
      S_DONE
   } state_type;

   state_type state_ff;

   // configuration
   logic [15:0] advance_ff;
   logic [15:0] pole_ff;
   logic        loop_enable_ff;

   // filter state
   logic [15:0]      period_ff;
   logic [RUN_W-1:0] run_ff;

   // per-event working registers
   logic [15:0] x_ff;
   logic        valid_ff;
   logic [31:0] prod_ff;

   // result register
   logic         rsp_valid_ff;
   rsp_item_type rsp_ff;

   // event checks and blend input
   logic        req_fire;
   logic [15:0] gap;
   logic        ev_valid;
   logic [17:0] sum;
   logic [15:0] x_in;
   logic [31:0] mult_res;
   logic [31:0] acc;
   logic [16:0] divisor;
   logic        div_start;
   logic [15:0] quotient;
   logic        rsp_free;
   logic [RUN_W-1:0] run_in;

   div_status_type div_status;

   assign req_fire = req_valid && req_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign rsp_free = !rsp_valid_ff || rsp_ready;

   // wrapped gap and range checks
   always_comb begin
      gap = req_item.capture_now - req_item.capture_before;
      ev_valid = 1'b1;
      if (req_item.overflow_count > 8'd1) begin
         ev_valid = 1'b0;
      end
      if (req_item.overflow_count == 8'd1 &&
          req_item.capture_now > req_item.capture_before) begin
         ev_valid = 1'b0;
      end
      if (gap > GAP_LIMIT) begin
         ev_valid = 1'b0;
      end
   end

   // gap plus signed advance, negative clamps to zero, then the step shift
   always_comb begin
      sum = {2'b00, gap} + {{2{advance_ff[15]}}, advance_ff};
      if (sum[17]) begin
         x_in = '0;
      end else begin
         x_in = 16'(sum[16:0] >> STEP_SHIFT);
      end
   end

   // product fits 32 bits and the sum with x never carries out
   assign mult_res  = period_ff * pole_ff;
   assign acc       = prod_ff + {16'd0, x_ff};
   assign divisor   = {1'b0, pole_ff} + 17'd1;
   assign div_start = (state_ff == S_LOAD);

   // lock run counter, saturating
   assign run_in = (run_ff < RUN_MAX) ? run_ff + RUN_W'(1) : run_ff;

   bcpf_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (acc),
      .divisor  (divisor),
      .status   (div_status),
      .quotient (quotient)
   );

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         advance_ff     <= '0;
         pole_ff        <= '0;
         loop_enable_ff <= 1'b0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_TIMING_ADVANCE: advance_ff     <= csr_wdata;
            CSR_FILTER_POLE:    pole_ff        <= csr_wdata;
            CSR_LOOP_ENABLE:    loop_enable_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // sequencer, filter state and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         period_ff    <= '0;
         run_ff       <= '0;
         valid_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // result taken; a new one loaded in S_DONE overrides this
         if (rsp_valid_ff && rsp_ready && state_ff != S_DONE) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (req_fire) begin
                  valid_ff <= ev_valid;
                  x_ff     <= x_in;
                  if (ev_valid) begin
                     state_ff <= S_MUL;
                  end else begin
                     // rejected event: period held, lock run restarts
                     run_ff   <= '0;
                     state_ff <= S_DONE;
                  end
               end
            end
            S_MUL: begin
               prod_ff  <= mult_res;
               state_ff <= S_LOAD;
            end
            S_LOAD: begin
               // divider takes the blend sum this cycle
               state_ff <= S_DIV;
            end
            S_DIV: begin
               if (div_status.done) begin
                  period_ff <= quotient;
                  run_ff    <= run_in;
                  state_ff  <= S_DONE;
               end
            end
            S_DONE: begin
               // wait for the output register to drain
               if (rsp_free) begin
                  rsp_valid_ff         <= 1'b1;
                  rsp_ff.period        <= period_ff;
                  rsp_ff.gap_valid     <= valid_ff;
                  rsp_ff.lock_ready    <= valid_ff && (run_ff >= RUN_MAX);
                  rsp_ff.commutate     <= loop_enable_ff;
                  state_ff             <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   `include "bemf_commutation_period_filter_macros.svh"

   // an accepted event keeps the block busy on the next cycle
   `BCPF_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_fire, !req_ready, "ready after accept")
   // lock is only reported on a valid event
   `BCPF_ASSERT_SAME(a_lock_needs_valid, clock, reset, rsp_valid_ff && rsp_ff.lock_ready, rsp_ff.gap_valid, "lock on invalid event")
   // run counter saturates at its limit
   `BCPF_ASSERT_SAME(a_run_bounded, clock, reset, 1'b1, run_ff <= RUN_MAX, "run count beyond limit")
   // divider only runs while the sequencer waits on it
   `BCPF_ASSERT_SAME(a_div_in_div, clock, reset, div_status.busy, state_ff == S_DIV, "divider busy outside divide")

endmodule
